// ===== sv/ipdt_pkg.sv =====
// Shared constants for the infrared pulse-distance byte transmitter:
// register indexes, register reset values, item operation codes, phase codes and the frame length.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipdt_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_CARRIER_HIGH = 3'd0;
	localparam logic [2:0] REG_CARRIER_LOW  = 3'd1;
	localparam logic [2:0] REG_BURST_PULSES = 3'd2;
	localparam logic [2:0] REG_SPACE_ZERO   = 3'd3;
	localparam logic [2:0] REG_SPACE_ONE    = 3'd4;

	// Register reset values
	localparam logic [15:0] CARRIER_HIGH_RST = 16'd10;
	localparam logic [15:0] CARRIER_LOW_RST  = 16'd17;
	localparam logic [7:0]  BURST_PULSES_RST = 8'd16;
	localparam logic [15:0] SPACE_ZERO_RST   = 16'd480;
	localparam logic [15:0] SPACE_ONE_RST    = 16'd1430;

	// Data bits sent per frame before the closing burst
	localparam logic [3:0] BITS_PER_FRAME = 4'd8;

	// Item operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// Transmit phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;
	localparam logic [1:0] PH_SPACE = 2'd3;

endpackage

`default_nettype wire

// ===== sv/ir_pulse_distance_byte_transmitter_top.sv =====
// Top level of the infrared pulse-distance byte transmitter: registers,
// transmit sequencer and result skid buffer. Depends on ipdt_pkg.
//
// Usage:
// The item channel (item_valid / item_stall) carries one item per transfer:
// operation 0 is one microsecond tick of the waveform, operation 1 starts a
// frame with the byte on payload. Every item gives exactly one result on the
// result channel (res_valid / res_stall): ir_level for that tick, busy_res,
// frame_done on the tick that ends the closing burst, and start_rejected when
// a start arrives during a frame.
// Each item is handled combinationally by the sequencer between the transmit
// state and result registers, so the block takes one item per cycle while
// item_stall is low; its result enters the output or the skid register.
// Results pass through an output register backed by a one-entry skid
// register. While the receiver stalls, one more item is taken into the skid
// register, then item_stall rises until the output register drains.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
// always ready; a write takes effect for the next item.
// Reset clears the sequencer to idle, loads the register defaults and
// empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_distance_byte_transmitter_top
	import ipdt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        operation,
	input  wire logic [7:0]  payload,
	// result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             ir_level,
	output logic             busy_res,
	output logic             frame_done,
	output logic             start_rejected,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	typedef struct packed {
		logic level;
		logic busy;
		logic done;
		logic rej;
	} result_t;

	// configuration registers
	logic [15:0] carrier_high_q;
	logic [15:0] carrier_low_q;
	logic [7:0]  burst_pulses_q;
	logic [15:0] space_zero_q;
	logic [15:0] space_one_q;

	// transmit state
	logic [1:0]  phase_q;
	logic [3:0]  bit_pos_q;
	logic [7:0]  pulse_cnt_q;
	logic [15:0] tick_cnt_q;
	logic [7:0]  shift_q;

	logic [1:0]  phase_d;
	logic [3:0]  bit_pos_d;
	logic [7:0]  pulse_cnt_d;
	logic [15:0] tick_cnt_d;
	logic [7:0]  shift_d;
	result_t     res_d;

	// result buffer
	result_t     out_q;
	logic        out_valid_q;
	result_t     skid_q;
	logic        skid_valid_q;

	logic        item_xfer;
	logic        res_xfer;
	logic [15:0] tick_inc;
	logic [7:0]  pulse_inc;
	logic [15:0] space_len;

	assign cfg_ready  = 1'b1;
	assign item_stall = skid_valid_q;
	assign item_xfer  = item_valid & ~skid_valid_q;
	assign res_xfer   = out_valid_q & ~res_stall;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_high_q <= CARRIER_HIGH_RST;
			carrier_low_q  <= CARRIER_LOW_RST;
			burst_pulses_q <= BURST_PULSES_RST;
			space_zero_q   <= SPACE_ZERO_RST;
			space_one_q    <= SPACE_ONE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CARRIER_HIGH: carrier_high_q <= cfg_data;
				REG_CARRIER_LOW:  carrier_low_q  <= cfg_data;
				REG_BURST_PULSES: burst_pulses_q <= cfg_data[7:0];
				REG_SPACE_ZERO:   space_zero_q   <= cfg_data;
				REG_SPACE_ONE:    space_one_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign tick_inc  = tick_cnt_q + 16'd1;
	assign pulse_inc = pulse_cnt_q + 8'd1;
	assign space_len = shift_q[0] ? space_one_q : space_zero_q;

	// advance the sequencer by one item
	always_comb begin
		phase_d     = phase_q;
		bit_pos_d   = bit_pos_q;
		pulse_cnt_d = pulse_cnt_q;
		tick_cnt_d  = tick_cnt_q;
		shift_d     = shift_q;
		res_d       = '0;

		if (operation == OP_START) begin
			if (phase_q != PH_IDLE) begin
				res_d.rej = 1'b1;
			end else begin
				shift_d     = payload;
				bit_pos_d   = 4'd0;
				phase_d     = PH_HIGH;
				tick_cnt_d  = 16'd0;
				pulse_cnt_d = 8'd0;
			end
		end else begin
			case (phase_q)
				PH_HIGH: begin
					res_d.level = 1'b1;
					tick_cnt_d  = tick_inc;
					if (tick_inc >= carrier_high_q) begin
						phase_d    = PH_LOW;
						tick_cnt_d = 16'd0;
					end
				end
				PH_LOW: begin
					tick_cnt_d = tick_inc;
					if (tick_inc >= carrier_low_q) begin
						tick_cnt_d  = 16'd0;
						pulse_cnt_d = pulse_inc;
						if (pulse_inc >= burst_pulses_q) begin
							pulse_cnt_d = 8'd0;
							if (bit_pos_q >= BITS_PER_FRAME) begin
								// closing burst over
								phase_d    = PH_IDLE;
								res_d.done = 1'b1;
							end else if (space_len == 16'd0) begin
								// empty space: next burst right away
								shift_d   = {1'b0, shift_q[7:1]};
								bit_pos_d = bit_pos_q + 4'd1;
								phase_d   = PH_HIGH;
							end else begin
								phase_d = PH_SPACE;
							end
						end else begin
							phase_d = PH_HIGH;
						end
					end
				end
				PH_SPACE: begin
					tick_cnt_d = tick_inc;
					if (tick_inc >= space_len) begin
						shift_d     = {1'b0, shift_q[7:1]};
						bit_pos_d   = bit_pos_q + 4'd1;
						phase_d     = PH_HIGH;
						tick_cnt_d  = 16'd0;
						pulse_cnt_d = 8'd0;
					end
				end
				default: ;
			endcase
		end
		res_d.busy = (phase_d != PH_IDLE);
	end

	// hold transmit state between transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_pos_q   <= 4'd0;
			pulse_cnt_q <= 8'd0;
			tick_cnt_q  <= 16'd0;
			shift_q     <= 8'd0;
		end else if (item_xfer) begin
			phase_q     <= phase_d;
			bit_pos_q   <= bit_pos_d;
			pulse_cnt_q <= pulse_cnt_d;
			tick_cnt_q  <= tick_cnt_d;
			shift_q     <= shift_d;
		end
	end

	// output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || res_xfer) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= item_xfer;
			end
		end else if (item_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || res_xfer) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (item_xfer) begin
				out_q <= res_d;
			end
		end else if (item_xfer) begin
			skid_q <= res_d;
		end
	end

	assign res_valid      = out_valid_q;
	assign ir_level       = out_q.level;
	assign busy_res       = out_q.busy;
	assign frame_done     = out_q.done;
	assign start_rejected = out_q.rej;

	// a skid entry only exists behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without output entry");

	// the frame ends idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && frame_done) |-> !busy_res)
		else $error("frame_done with busy_res set");

	// a rejected start leaves the frame running
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && start_rejected) |-> (busy_res && !ir_level && !frame_done))
		else $error("rejected start outside a frame");

	// carrier high only inside a frame
	a_level_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && ir_level) |-> busy_res)
		else $error("ir_level high while idle");

	// the sequencer moves only on a transfer
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!item_xfer |=> ($stable(phase_q) && $stable(tick_cnt_q)))
		else $error("transmit state changed without a transfer");

endmodule

`default_nettype wire
